[design/bsfn_pkg.sv]
// Shared types and constants for the bit-vector set with find-next.
// No dependencies; imported by every module of the block.
`default_nettype none

package bsfn_pkg;

  localparam int MODE_W    = 3;
  localparam int ELEM_W    = 10;
  localparam int WIDX_W    = 5;
  localparam int DATA_W    = 32;
  localparam int S_TDATA_W = 48;
  localparam int M_TDATA_W = 16;
  localparam int M_TUSER_W = 2;
  localparam int BASE_W    = 12;
  localparam int WNUM_W    = 8;
  localparam int DIV_SH    = 18;
  localparam int PROD_W    = ELEM_W + 1 + 16;

  localparam logic [ELEM_W-1:0] LARGEST_RESET = '1;

  localparam logic [MODE_W-1:0] MODE_TEST  = 3'd0;
  localparam logic [MODE_W-1:0] MODE_SET   = 3'd1;
  localparam logic [MODE_W-1:0] MODE_CLEAR = 3'd2;
  localparam logic [MODE_W-1:0] MODE_FIRST = 3'd3;
  localparam logic [MODE_W-1:0] MODE_NEXT  = 3'd4;
  localparam logic [MODE_W-1:0] MODE_OR    = 3'd5;
  localparam logic [MODE_W-1:0] MODE_AND   = 3'd6;

  typedef enum logic [3:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_CHECK,
    ST_DIV,
    ST_BASE,
    ST_READ,
    ST_EVAL,
    ST_RESULT
  } state_t;

  typedef enum logic [1:0] {
    KIND_ELEM,
    KIND_SCAN,
    KIND_WORD,
    KIND_NOP
  } kind_t;

  typedef struct packed {
    logic clr_wr;
    logic load_item;
    logic res_init;
    logic load_word;
    logic div_q;
    logic div_base;
    logic rd;
    logic eval;
    logic adv;
    logic out_load;
  } cmd_t;

  typedef struct packed {
    kind_t kind;
    logic  bad;
    logic  hit;
    logic  last_word;
    logic  clr_last;
  } sts_t;

endpackage

`default_nettype wire

[design/bsfn_dpath.sv]
// Datapath: member word memory, cursor, limit register, word/bit split,
// masking, priority encoder and result registers. Uses bsfn_pkg.
`default_nettype none

module bsfn_dpath import bsfn_pkg::*; #(
  parameter int SET_SIZE  = 1024,
  parameter int WORD_BITS = 32
) (
  input  logic              clk,
  input  logic              rst,
  input  cmd_t              cmd,
  output sts_t              sts,
  input  logic [MODE_W-1:0] in_mode,
  input  logic [ELEM_W-1:0] in_element,
  input  logic [WIDX_W-1:0] in_word_index,
  input  logic [DATA_W-1:0] in_word_data,
  input  logic              cfg_valid,
  input  logic [ELEM_W-1:0] cfg_data,
  output logic              out_found,
  output logic [ELEM_W-1:0] out_found_element,
  output logic              out_range_error
);

  localparam int NWORDS  = (SET_SIZE + WORD_BITS - 1) / WORD_BITS;
  localparam int AW      = (NWORDS > 1) ? $clog2(NWORDS) : 1;
  localparam int BIT_W   = $clog2(WORD_BITS);
  localparam int DIV_M   = ((1 << DIV_SH) + WORD_BITS - 1) / WORD_BITS;
  localparam int LIM_CAP = (SET_SIZE - 1 < (1 << ELEM_W) - 1) ? SET_SIZE - 1
                                                               : (1 << ELEM_W) - 1;

  logic [WORD_BITS-1:0] mem [NWORDS];

  logic [ELEM_W-1:0]    largest;
  logic [ELEM_W-1:0]    cursor;
  logic [MODE_W-1:0]    mode_r;
  logic [ELEM_W-1:0]    elem_r;
  logic [WIDX_W-1:0]    widx_r;
  logic [WORD_BITS-1:0] data_r;
  logic [WNUM_W-1:0]    wnum;
  logic [BASE_W-1:0]    base;
  logic [BIT_W-1:0]     bitpos;
  logic [WORD_BITS-1:0] rdata;
  logic [AW-1:0]        clr_addr;
  logic                 res_found;
  logic [ELEM_W-1:0]    res_fel;
  logic                 res_err;

  logic [ELEM_W-1:0]    lim;
  kind_t                kind;
  logic [ELEM_W:0]      start;
  logic [ELEM_W:0]      x;
  logic [BASE_W-1:0]    wbase;
  logic                 bad;
  logic [PROD_W-1:0]    prod;
  logic [BASE_W-1:0]    qmul;
  logic [BASE_W-1:0]    xdiff;
  logic [BASE_W-1:0]    top;
  logic [WORD_BITS-1:0] vmask;
  logic [WORD_BITS-1:0] lowmask;
  logic [WORD_BITS-1:0] cand;
  logic [WORD_BITS-1:0] onehot;
  logic [WORD_BITS-1:0] wdata;
  logic [BIT_W-1:0]     pos;
  logic                 hit;
  logic [ELEM_W-1:0]    hit_elem;
  logic                 wr_mode;
  logic                 wr_en;
  logic [AW-1:0]        waddr;
  logic [AW-1:0]        raddr;

  assign lim = (largest > ELEM_W'(LIM_CAP)) ? ELEM_W'(LIM_CAP) : largest;

  always_comb begin
    unique case (mode_r) inside
      MODE_TEST, MODE_SET, MODE_CLEAR: kind = KIND_ELEM;
      MODE_FIRST, MODE_NEXT:           kind = KIND_SCAN;
      MODE_OR, MODE_AND:               kind = KIND_WORD;
      default:                         kind = KIND_NOP;
    endcase
  end

  assign start = (mode_r == MODE_FIRST) ? '0 : {1'b0, cursor} + (ELEM_W + 1)'(1);
  assign x     = (kind == KIND_SCAN) ? start : {1'b0, elem_r};
  assign wbase = BASE_W'(widx_r) * BASE_W'(WORD_BITS);

  always_comb begin
    case (kind)
      KIND_ELEM: bad = elem_r > lim;
      KIND_SCAN: bad = start > {1'b0, lim};
      KIND_WORD: bad = (32'(widx_r) >= NWORDS) || (wbase > BASE_W'(lim));
      default:   bad = 1'b0;
    endcase
  end

  // split x into word number and bit position by reciprocal multiply
  assign prod  = PROD_W'(x) * PROD_W'(DIV_M);
  assign qmul  = BASE_W'(wnum) * BASE_W'(WORD_BITS);
  assign xdiff = BASE_W'(x) - qmul;

  assign top     = BASE_W'(lim) - base;
  assign vmask   = (top >= BASE_W'(WORD_BITS - 1)) ? '1
                 : ({WORD_BITS{1'b1}} >> (BIT_W'(WORD_BITS - 1) - top[BIT_W-1:0]));
  assign lowmask = {WORD_BITS{1'b1}} << bitpos;
  assign cand    = rdata & vmask & lowmask;
  assign onehot  = WORD_BITS'(1) << bitpos;
  assign hit     = |cand;

  always_comb begin
    pos = '0;
    for (int i = WORD_BITS - 1; i >= 0; i--) begin
      if (cand[i]) begin
        pos = BIT_W'(i);
      end
    end
  end

  assign hit_elem = ELEM_W'(base + BASE_W'(pos));

  always_comb begin
    wr_mode = 1'b1;
    case (mode_r)
      MODE_SET:   wdata = rdata | onehot;
      MODE_CLEAR: wdata = rdata & ~onehot;
      MODE_OR:    wdata = rdata | (data_r & vmask);
      MODE_AND:   wdata = rdata & (data_r | ~vmask);
      default: begin
        wdata   = rdata;
        wr_mode = 1'b0;
      end
    endcase
  end

  assign wr_en = cmd.clr_wr | (cmd.eval & wr_mode);
  assign waddr = cmd.clr_wr ? clr_addr : AW'(wnum);
  assign raddr = cmd.adv ? AW'(wnum + WNUM_W'(1)) : AW'(wnum);

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[waddr] <= cmd.clr_wr ? '0 : wdata;
    end
    if (cmd.rd || cmd.adv) begin
      rdata <= mem[raddr];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      largest  <= LARGEST_RESET;
      cursor   <= '0;
      clr_addr <= '0;
    end else begin
      if (cfg_valid) begin
        largest <= cfg_data;
      end
      if (cmd.clr_wr) begin
        clr_addr <= clr_addr + AW'(1);
      end
      if (cmd.eval && kind == KIND_SCAN && hit) begin
        cursor <= hit_elem;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_item) begin
      mode_r <= in_mode;
      elem_r <= in_element;
      widx_r <= in_word_index;
      data_r <= WORD_BITS'(in_word_data);
    end
    if (cmd.load_word) begin
      wnum   <= WNUM_W'(widx_r);
      base   <= wbase;
      bitpos <= '0;
    end
    if (cmd.div_q) begin
      wnum <= WNUM_W'(prod >> DIV_SH);
    end
    if (cmd.div_base) begin
      base   <= qmul;
      bitpos <= xdiff[BIT_W-1:0];
    end
    if (cmd.adv) begin
      wnum   <= wnum + WNUM_W'(1);
      base   <= base + BASE_W'(WORD_BITS);
      bitpos <= '0;
    end
    if (cmd.res_init) begin
      res_found <= 1'b0;
      res_fel   <= '0;
      res_err   <= bad && (kind == KIND_ELEM || kind == KIND_WORD);
    end
    if (cmd.eval) begin
      if (mode_r == MODE_TEST) begin
        res_found <= rdata[bitpos];
      end
      if (kind == KIND_SCAN && hit) begin
        res_found <= 1'b1;
        res_fel   <= hit_elem;
      end
    end
    if (cmd.out_load) begin
      out_found         <= res_found;
      out_found_element <= res_fel;
      out_range_error   <= res_err;
    end
  end

  assign sts.kind      = kind;
  assign sts.bad       = bad;
  assign sts.hit       = hit;
  assign sts.last_word = (base + BASE_W'(WORD_BITS)) > BASE_W'(lim);
  assign sts.clr_last  = clr_addr == AW'(NWORDS - 1);

endmodule

`default_nettype wire

[design/bsfn_ctrl.sv]
// Controller state machine: sequences clearing, range check, word/bit split,
// memory read, evaluation or scan, and result hand-off. Uses bsfn_pkg.
`default_nettype none

module bsfn_ctrl import bsfn_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  logic in_valid,
  output logic in_ready,
  output logic out_valid,
  input  logic out_ready,
  input  sts_t sts,
  output cmd_t cmd
);

  state_t state;
  state_t state_next;
  logic   scan_more;

  assign scan_more = (sts.kind == KIND_SCAN) && !sts.hit && !sts.last_word;

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_CLEAR;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (cmd.out_load) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      ST_CLEAR: begin
        if (sts.clr_last) state_next = ST_IDLE;
      end
      ST_IDLE: begin
        if (in_valid) state_next = ST_CHECK;
      end
      ST_CHECK: begin
        if (sts.kind == KIND_NOP || sts.bad) state_next = ST_RESULT;
        else if (sts.kind == KIND_WORD)      state_next = ST_READ;
        else                                 state_next = ST_DIV;
      end
      ST_DIV:  state_next = ST_BASE;
      ST_BASE: state_next = ST_READ;
      ST_READ: state_next = ST_EVAL;
      ST_EVAL: begin
        if (!scan_more) state_next = ST_RESULT;
      end
      ST_RESULT: begin
        if (!out_valid || out_ready) state_next = ST_IDLE;
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd      = '0;
    in_ready = 1'b0;
    unique case (state)
      ST_CLEAR: cmd.clr_wr = 1'b1;
      ST_IDLE: begin
        in_ready      = 1'b1;
        cmd.load_item = in_valid;
      end
      ST_CHECK: begin
        cmd.res_init  = 1'b1;
        cmd.load_word = (sts.kind == KIND_WORD) && !sts.bad;
      end
      ST_DIV:  cmd.div_q    = 1'b1;
      ST_BASE: cmd.div_base = 1'b1;
      ST_READ: cmd.rd       = 1'b1;
      ST_EVAL: begin
        cmd.eval = 1'b1;
        cmd.adv  = scan_more;
      end
      ST_RESULT: cmd.out_load = !out_valid || out_ready;
      default: cmd = '0;
    endcase
  end

endmodule

`default_nettype wire

[design/bitset_with_find_next.sv]
// Top level of the bit-vector set with find-next.
// Instantiates bsfn_ctrl and bsfn_dpath; uses bsfn_pkg.
//
// Usage:
//   s_axis carries one item: tuser = mode; tdata = element, word_index,
//   word_data. m_axis returns one result per item: tdata = found_element,
//   tuser = found, range_error. cfg_valid/cfg_data writes largest_element
//   (always ready); write it only while the block is idle.
//   One item is in work at a time. States from acceptance to m_axis_tvalid:
//     mode 7 or out-of-range item: CHECK, RESULT
//     or word / and word:          CHECK, READ, EVAL, RESULT
//     test / set / clear:          CHECK, DIV, BASE, READ, EVAL, RESULT
//     first / next:                as test, with EVAL repeated per word scanned
//   A scan examines one word per cycle. The next item is taken in IDLE, which
//   follows RESULT, where the result is registered. The scan rate is set by
//   the single memory read port and the priority encoder over one word. A
//   finished result waits in the output register while the next item is
//   worked on; if it is still not taken when that item finishes, the block
//   holds until it is.
//   Reset empties the set, zeroes the cursor and restores largest_element to
//   1023; a clearing pass over the NWORDS words (32 by default) follows,
//   during which s_axis_tready stays low.
`default_nettype none

module bitset_with_find_next import bsfn_pkg::*; #(
  parameter int SET_SIZE  = 1024,
  parameter int WORD_BITS = 32
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 s_axis_tvalid,
  output logic                 s_axis_tready,
  input  logic [S_TDATA_W-1:0] s_axis_tdata,   // element, word_index, word_data
  input  logic [MODE_W-1:0]    s_axis_tuser,   // mode
  output logic                 m_axis_tvalid,
  input  logic                 m_axis_tready,
  output logic [M_TDATA_W-1:0] m_axis_tdata,   // found_element
  output logic [M_TUSER_W-1:0] m_axis_tuser,   // found, range_error
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [ELEM_W-1:0]    cfg_data
);

  cmd_t              cmd;
  sts_t              sts;
  logic              out_found;
  logic [ELEM_W-1:0] out_found_element;
  logic              out_range_error;

  assign cfg_ready = 1'b1;

  bsfn_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (s_axis_tvalid),
    .in_ready  (s_axis_tready),
    .out_valid (m_axis_tvalid),
    .out_ready (m_axis_tready),
    .sts       (sts),
    .cmd       (cmd)
  );

  bsfn_dpath #(
    .SET_SIZE  (SET_SIZE),
    .WORD_BITS (WORD_BITS)
  ) u_dpath (
    .clk               (clk),
    .rst               (rst),
    .cmd               (cmd),
    .sts               (sts),
    .in_mode           (s_axis_tuser),
    .in_element        (s_axis_tdata[ELEM_W-1:0]),
    .in_word_index     (s_axis_tdata[ELEM_W+WIDX_W-1:ELEM_W]),
    .in_word_data      (s_axis_tdata[ELEM_W+WIDX_W+DATA_W-1:ELEM_W+WIDX_W]),
    .cfg_valid         (cfg_valid),
    .cfg_data          (cfg_data),
    .out_found         (out_found),
    .out_found_element (out_found_element),
    .out_range_error   (out_range_error)
  );

  assign m_axis_tdata = M_TDATA_W'(out_found_element);
  assign m_axis_tuser = {out_range_error, out_found};

endmodule

`default_nettype wire

[design/bsfn_chk.sv]
// Port-level checker for bitset_with_find_next, attached by bind.
// Uses bsfn_pkg.
`default_nettype none

module bsfn_chk import bsfn_pkg::*; (
  input logic                 clk,
  input logic                 rst,
  input logic                 s_axis_tvalid,
  input logic                 s_axis_tready,
  input logic                 m_axis_tvalid,
  input logic                 m_axis_tready,
  input logic [M_TDATA_W-1:0] m_axis_tdata,
  input logic [M_TUSER_W-1:0] m_axis_tuser
);

  a_clear_after_reset: assert property (@(posedge clk)
    rst |=> !s_axis_tready)
    else $error("input ready during clearing pass");

  a_one_at_a_time: assert property (@(posedge clk) disable iff (rst)
    (s_axis_tvalid && s_axis_tready) |=> !s_axis_tready)
    else $error("item taken while another is in work");

  a_element_only_when_found: assert property (@(posedge clk) disable iff (rst)
    (m_axis_tvalid && !m_axis_tuser[0]) |-> (m_axis_tdata == '0))
    else $error("found_element nonzero without found");

  a_found_excludes_error: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid |-> !(m_axis_tuser[0] && m_axis_tuser[1]))
    else $error("found and range_error both set");

  a_result_holds: assert property (@(posedge clk) disable iff (rst)
    (m_axis_tvalid && !m_axis_tready) |=>
      (m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser)))
    else $error("stalled result changed");

endmodule

bind bitset_with_find_next bsfn_chk u_bsfn_chk (
  .clk           (clk),
  .rst           (rst),
  .s_axis_tvalid (s_axis_tvalid),
  .s_axis_tready (s_axis_tready),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tuser  (m_axis_tuser)
);

`default_nettype wire
